>>> sv/uaoc_pkg.sv
`timescale 1ns / 1ps
// Package for the UTF-8 Arabic-only checker: state type, byte classes and
// the code point range check. No dependencies.
package uaoc_pkg;

   localparam logic [7:0] AsciiLimit = 8'h80;

   // Lead byte masks and patterns
   localparam logic [7:0] Lead2Mask = 8'hE0;
   localparam logic [7:0] Lead2Pat  = 8'hC0;
   localparam logic [7:0] Lead3Mask = 8'hF0;
   localparam logic [7:0] Lead3Pat  = 8'hE0;
   localparam logic [7:0] Lead4Mask = 8'hF8;
   localparam logic [7:0] Lead4Pat  = 8'hF0;

   localparam logic [2:0] LenNone = 3'd0;
   localparam logic [2:0] Len2    = 3'd2;
   localparam logic [2:0] Len3    = 3'd3;
   localparam logic [2:0] Len4    = 3'd4;

   localparam int CpW = 21;

   localparam logic [CpW-1:0] Ar0Lo = 21'h00600;
   localparam logic [CpW-1:0] Ar0Hi = 21'h006FF;
   localparam logic [CpW-1:0] Ar1Lo = 21'h00750;
   localparam logic [CpW-1:0] Ar1Hi = 21'h0077F;
   localparam logic [CpW-1:0] Ar2Lo = 21'h008A0;
   localparam logic [CpW-1:0] Ar2Hi = 21'h008FF;
   localparam logic [CpW-1:0] Ar3Lo = 21'h0FB50;
   localparam logic [CpW-1:0] Ar3Hi = 21'h0FDFF;
   localparam logic [CpW-1:0] Ar4Lo = 21'h0FE70;
   localparam logic [CpW-1:0] Ar4Hi = 21'h0FEFF;

   typedef struct packed {
      logic [2:0][7:0] pending_bytes;
      logic [1:0]      pending_count;
      logic [2:0]      sequence_length;
      logic            failed;
   } state_type;

   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      len = LenNone;
      if ((b & Lead2Mask) == Lead2Pat)      len = Len2;
      else if ((b & Lead3Mask) == Lead3Pat) len = Len3;
      else if ((b & Lead4Mask) == Lead4Pat) len = Len4;
      return len;
   endfunction

   // ASCII letter or underscore
   function automatic logic ascii_bad(input logic [7:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || (b == 8'h5F);
   endfunction

   // Decoded code point is nonzero and outside every Arabic block
   function automatic logic seq_bad(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic [7:0] b3,
                                    input logic [2:0] len);
      logic [CpW-1:0] cp;
      logic           arabic;
      unique case (len)
         Len2:    cp = {10'd0, b0[4:0], b1[5:0]};
         Len3:    cp = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
         default: cp = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
      endcase
      arabic = (cp >= Ar0Lo && cp <= Ar0Hi) || (cp >= Ar1Lo && cp <= Ar1Hi) ||
               (cp >= Ar2Lo && cp <= Ar2Hi) || (cp >= Ar3Lo && cp <= Ar3Hi) ||
               (cp >= Ar4Lo && cp <= Ar4Hi);
      return (cp != '0) && !arabic;
   endfunction

endpackage

>>> sv/utf8_arabic_only_checker_unit.sv
`timescale 1ns / 1ps
// Channel  | ports                                  | direction
// ---------+----------------------------------------+----------
// request  | req_valid, req_stall, req_data_byte, req_last | in
// response | rsp_valid, rsp_stall, rsp_is_arabic    | out
//
// One byte per cycle while req_stall is low: a byte waits in the input register,
// where the decoder state is updated; a final byte also loads the response register.
// The verdict is valid once its final byte leaves the input register.
// Synchronous active-high reset clears all decoder state.
// A held verdict stalls only a following final byte; other bytes keep flowing.
// Depends on uaoc_pkg and uaoc_step.
module utf8_arabic_only_checker_unit
   import uaoc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_arabic
);

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   state_type  state_ff, state_in;
   logic       rsp_valid_ff;
   logic       rsp_is_arabic_ff;
   logic       verdict;
   logic       advance;
   logic       in_acc;

   assign advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !advance;
   assign in_acc      = req_valid && !req_stall;
   assign s1_valid_in = in_acc || (s1_valid_ff && !advance);

   uaoc_step u_step (
      .state_cur (state_ff),
      .data_byte (s1_byte_ff),
      .last      (s1_last_ff),
      .state_nxt (state_in),
      .is_arabic (verdict)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (advance) state_ff <= state_in;
         if (advance && s1_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_acc) begin
         s1_byte_ff <= req_data_byte;
         s1_last_ff <= req_last;
      end
      if (advance && s1_last_ff) rsp_is_arabic_ff <= verdict;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_is_arabic = rsp_is_arabic_ff;

   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance && s1_last_ff))
      else $error("verdict appeared without a final byte");

   a_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (advance && s1_last_ff) |=> (state_ff.pending_count == 2'd0 &&
                                   state_ff.sequence_length == LenNone && !state_ff.failed))
      else $error("decoder state not cleared after final byte");

   a_count_needs_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff.pending_count != 2'd0) |-> (state_ff.sequence_length != LenNone))
      else $error("bytes buffered with no sequence in progress");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_is_arabic_ff)))
      else $error("held verdict overwritten");

endmodule

>>> sv/uaoc_tail_scan.sv
`timescale 1ns / 1ps
// End-of-string parse of up to four buffered bytes (lead byte first).
// Depends on uaoc_pkg.
module uaoc_tail_scan
   import uaoc_pkg::*;
(
   input  logic [3:0][7:0] tail_bytes,
   input  logic [2:0]      tail_len,
   output logic            tail_bad
);

   logic [6:0][7:0] padded;

   assign padded = {24'd0, tail_bytes};

   // Walk the four positions; reach marks where a parse step starts.
   always_comb begin
      logic [3:0] reach;
      logic [2:0] len;
      logic [3:0] adv;
      logic       fit;
      logic       active;
      reach    = 4'b0001;
      tail_bad = 1'b0;
      for (int i = 0; i < 4; i++) begin
         len    = lead_len(padded[i]);
         fit    = (len != LenNone) &&
                  ({1'b0, 3'(i)} + {1'b0, len} <= {1'b0, tail_len});
         adv    = fit ? {1'b0, len} : 4'd1;
         active = reach[i] && ({1'b0, 3'(i)} < {1'b0, tail_len});
         if (active) begin
            if (padded[i] < AsciiLimit) begin
               if (ascii_bad(padded[i])) tail_bad = 1'b1;
            end else if (fit) begin
               if (seq_bad(padded[i], padded[i+1], padded[i+2], padded[i+3], len))
                  tail_bad = 1'b1;
            end
         end
         for (int j = i + 1; j < 4; j++) begin
            if (active && (adv == 4'(j - i))) reach[j] = 1'b1;
         end
      end
   end

endmodule

>>> sv/uaoc_step.sv
`timescale 1ns / 1ps
// One byte step: next decoder state and the verdict for a final byte.
// Depends on uaoc_pkg and uaoc_tail_scan.
module uaoc_step
   import uaoc_pkg::*;
(
   input  state_type  state_cur,
   input  logic [7:0] data_byte,
   input  logic       last,
   output state_type  state_nxt,
   output logic       is_arabic
);

   logic [7:0] s0, s1, s2, s3;
   logic [2:0] len;
   logic       idle;
   logic       tail_bad;

   // Buffered bytes with the current byte appended after them
   assign s0 = (state_cur.pending_count == 2'd0) ? data_byte : state_cur.pending_bytes[0];
   assign s1 = (state_cur.pending_count == 2'd1) ? data_byte : state_cur.pending_bytes[1];
   assign s2 = (state_cur.pending_count == 2'd2) ? data_byte : state_cur.pending_bytes[2];
   assign s3 = data_byte;

   assign len  = lead_len(data_byte);
   assign idle = (state_cur.sequence_length == LenNone) || (state_cur.pending_count == 2'd0);

   uaoc_tail_scan u_tail (
      .tail_bytes ({s3, s2, s1, s0}),
      .tail_len   ({1'b0, state_cur.pending_count} + 3'd1),
      .tail_bad   (tail_bad)
   );

   assign is_arabic = !(state_cur.failed || tail_bad);

   always_comb begin
      state_nxt = state_cur;
      if (last) begin
         state_nxt = '0;
      end else if (idle) begin
         if (data_byte < AsciiLimit) begin
            if (ascii_bad(data_byte)) state_nxt.failed = 1'b1;
         end else if (len != LenNone) begin
            state_nxt.pending_bytes[0] = data_byte;
            state_nxt.pending_count    = 2'd1;
            state_nxt.sequence_length  = len;
         end
      end else if ({1'b0, state_cur.pending_count} + 3'd1 >= state_cur.sequence_length) begin
         if (seq_bad(s0, s1, s2, s3, state_cur.sequence_length)) state_nxt.failed = 1'b1;
         state_nxt.pending_count   = 2'd0;
         state_nxt.sequence_length = LenNone;
      end else begin
         unique case (state_cur.pending_count)
            2'd1:    state_nxt.pending_bytes[1] = data_byte;
            2'd2:    state_nxt.pending_bytes[2] = data_byte;
            default: state_nxt.pending_bytes[0] = data_byte;
         endcase
         state_nxt.pending_count = state_cur.pending_count + 2'd1;
      end
   end

endmodule

>>> verif/utf8_arabic_only_checker_unit_checker.sv
`timescale 1ns / 1ps
// Verdict checker for utf8_arabic_only_checker_unit: follows accepted bytes,
// predicts one Arabic-only verdict per string and compares accepted verdicts.
// Standalone; instantiated by utf8_arabic_only_checker_unit_tb.
module arabic_verdict_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_is_arabic,
   output int         mismatch_count,
   output int         verdicts_owed
);

   // decoder state of the string in progress
   logic [7:0]  partial_seq [3] = '{default: 8'h00};
   int unsigned partial_cnt     = 0;
   int unsigned partial_len     = 0;
   bit          string_tainted  = 1'b0;

   bit verdict_fifo [$];
   bit want;
   int mismatches   = 0;
   int owed         = 0;
   int verdict_num  = 0;

   assign mismatch_count = mismatches;
   assign verdicts_owed  = owed;

   function automatic int unsigned seq_bytes(logic [7:0] lead);
      if (lead[7:5] == 3'b110)   return 2;
      if (lead[7:4] == 4'b1110)  return 3;
      if (lead[7:3] == 5'b11110) return 4;
      return 0;
   endfunction

   function automatic bit letter_or_underscore(logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
   endfunction

   // nonzero code point outside all five Arabic blocks
   function automatic bit foreign_code_point(logic [7:0] b0, logic [7:0] b1,
                                             logic [7:0] b2, logic [7:0] b3,
                                             int unsigned n);
      logic [20:0] cp;
      if (n == 2)
         cp = (21'(b0 & 8'h1F) << 6) | 21'(b1 & 8'h3F);
      else if (n == 3)
         cp = (21'(b0 & 8'h0F) << 12) | (21'(b1 & 8'h3F) << 6) | 21'(b2 & 8'h3F);
      else
         cp = (21'(b0 & 8'h07) << 18) | (21'(b1 & 8'h3F) << 12) |
              (21'(b2 & 8'h3F) << 6) | 21'(b3 & 8'h3F);
      if (cp == 21'h0) return 1'b0;
      return !((cp >= 21'h00600 && cp <= 21'h006FF) ||
               (cp >= 21'h00750 && cp <= 21'h0077F) ||
               (cp >= 21'h008A0 && cp <= 21'h008FF) ||
               (cp >= 21'h0FB50 && cp <= 21'h0FDFF) ||
               (cp >= 21'h0FE70 && cp <= 21'h0FEFF));
   endfunction

   task automatic absorb_byte(logic [7:0] b);
      logic [7:0]  s [4];
      int unsigned k;
      if (partial_len == 0 || partial_cnt == 0) begin
         if (b < 8'h80) begin
            if (letter_or_underscore(b)) string_tainted = 1'b1;
         end else if (seq_bytes(b) != 0) begin
            partial_seq[0] = b;
            partial_cnt    = 1;
            partial_len    = seq_bytes(b);
         end
      end else if (partial_cnt + 1 >= partial_len) begin
         s = '{default: 8'h00};
         for (k = 0; k < partial_cnt; k++) s[k] = partial_seq[k];
         s[partial_cnt] = b;
         if (foreign_code_point(s[0], s[1], s[2], s[3], partial_len))
            string_tainted = 1'b1;
         partial_cnt = 0;
         partial_len = 0;
      end else begin
         partial_seq[partial_cnt] = b;
         partial_cnt++;
      end
   endtask

   // final byte: buffered bytes plus this one are parsed again from the start,
   // so a cut-short lead is dropped and its followers stand on their own
   task automatic close_string(logic [7:0] final_byte);
      logic [7:0]  tail_bytes [7];
      int unsigned n, i, len;
      tail_bytes = '{default: 8'h00};
      for (i = 0; i < partial_cnt; i++) tail_bytes[i] = partial_seq[i];
      tail_bytes[partial_cnt] = final_byte;
      n = partial_cnt + 1;
      i = 0;
      while (i < n) begin
         if (tail_bytes[i] < 8'h80) begin
            if (letter_or_underscore(tail_bytes[i])) string_tainted = 1'b1;
            i++;
         end else begin
            len = seq_bytes(tail_bytes[i]);
            if (len != 0 && i + len <= n) begin
               if (foreign_code_point(tail_bytes[i], tail_bytes[i+1], tail_bytes[i+2],
                                      tail_bytes[i+3], len))
                  string_tainted = 1'b1;
               i += len;
            end else begin
               i++;
            end
         end
      end
      verdict_fifo.push_back(!string_tainted);
      partial_cnt    = 0;
      partial_len    = 0;
      string_tainted = 1'b0;
   endtask

   task automatic report_mismatch(string msg);
      $display("%0t: verdict %0d: %s", $time, verdict_num, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (req_last) close_string(req_data_byte);
            else          absorb_byte(req_data_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            if (verdict_fifo.size() == 0) begin
               report_mismatch($sformatf("is_arabic=%0b with no string pending",
                                         rsp_is_arabic));
            end else begin
               want = verdict_fifo.pop_front();
               if (rsp_is_arabic !== want)
                  report_mismatch($sformatf("is_arabic=%0b, expected %0b",
                                            rsp_is_arabic, want));
            end
            verdict_num++;
         end
         owed = verdict_fifo.size();
      end
   end

endmodule

>>> verif/utf8_arabic_only_checker_unit_tb.sv
`timescale 1ns / 1ps
// Testbench top for utf8_arabic_only_checker_unit: builds byte strings, drives
// them with random gaps and stalls, and gives the verdict from the checker.
// Depends on the DUT, uaoc_pkg and arabic_verdict_checker.
module utf8_arabic_only_checker_unit_tb;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   localparam int RandomItems   = 2000;
   localparam int GapMax        = 19;
   localparam int HoldCycles    = 300;
   localparam int HoldAtVerdict = 40;
   localparam int DrainCycles   = 10;
   localparam int WatchdogLimit = 4000;

   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last      = 1'b0;
   logic       rsp_stall     = 1'b0;
   logic       req_stall;
   logic       rsp_valid;
   logic       rsp_is_arabic;
   int         mismatch_count;
   int         verdicts_owed;

   byte_item_type byte_stream [$];
   int            idle_run       = 0;
   int            verdicts_taken = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   utf8_arabic_only_checker_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_is_arabic (rsp_is_arabic)
   );

   arabic_verdict_checker verdict_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_is_arabic  (rsp_is_arabic),
      .mismatch_count (mismatch_count),
      .verdicts_owed  (verdicts_owed)
   );

   // ---------------- string building ----------------

   function automatic void put_byte(logic [7:0] b);
      byte_stream.push_back('{data: b, last: 1'b0});
   endfunction

   function automatic void end_string();
      byte_item_type it;
      it = byte_stream.pop_back();
      it.last = 1'b1;
      byte_stream.push_back(it);
   endfunction

   function automatic int unsigned utf8_size(logic [20:0] cp);
      if (cp < 21'h80)    return 1;
      if (cp < 21'h800)   return 2;
      if (cp < 21'h10000) return 3;
      return 4;
   endfunction

   // encode cp in nbytes (overlong allowed), emitting only the first keep bytes
   function automatic void put_utf8(logic [20:0] cp, int unsigned nbytes,
                                    int unsigned keep);
      logic [7:0]  enc [4];
      int unsigned k;
      case (nbytes)
         1:       enc = '{{1'b0, cp[6:0]}, 8'h00, 8'h00, 8'h00};
         2:       enc = '{{3'b110, cp[10:6]}, {2'b10, cp[5:0]}, 8'h00, 8'h00};
         3:       enc = '{{4'b1110, cp[15:12]}, {2'b10, cp[11:6]}, {2'b10, cp[5:0]},
                          8'h00};
         default: enc = '{{5'b11110, cp[20:18]}, {2'b10, cp[17:12]},
                          {2'b10, cp[11:6]}, {2'b10, cp[5:0]}};
      endcase
      for (k = 0; k < keep; k++) put_byte(enc[k]);
   endfunction

   function automatic logic [20:0] arabic_cp();
      logic [20:0] lo, hi;
      case ($urandom_range(0, 4))
         0:       begin lo = 21'h00600; hi = 21'h006FF; end
         1:       begin lo = 21'h00750; hi = 21'h0077F; end
         2:       begin lo = 21'h008A0; hi = 21'h008FF; end
         3:       begin lo = 21'h0FB50; hi = 21'h0FDFF; end
         default: begin lo = 21'h0FE70; hi = 21'h0FEFF; end
      endcase
      case ($urandom_range(0, 3))
         0:       return lo;
         1:       return hi;
         default: return 21'($urandom_range(lo, hi));
      endcase
   endfunction

   // ASCII bytes that are neither letters nor underscore
   function automatic logic [7:0] neutral_ascii();
      case ($urandom_range(0, 4))
         0:       return 8'($urandom_range(8'h00, 8'h40));
         1:       return 8'($urandom_range(8'h5B, 8'h5E));
         2:       return 8'h60;
         3:       return 8'($urandom_range(8'h7B, 8'h7F));
         default: return 8'($urandom_range(8'h30, 8'h39));
      endcase
   endfunction

   // code points just outside the Arabic blocks
   function automatic logic [20:0] border_cp();
      case ($urandom_range(0, 9))
         0:       return 21'h005FF;
         1:       return 21'h00700;
         2:       return 21'h0074F;
         3:       return 21'h00780;
         4:       return 21'h0089F;
         5:       return 21'h00900;
         6:       return 21'h0FB4F;
         7:       return 21'h0FE00;
         8:       return 21'h0FE6F;
         default: return 21'h0FF00;
      endcase
   endfunction

   function automatic void put_clean_unit();
      logic [20:0] cp;
      case ($urandom_range(0, 11))
         0, 1, 2, 3, 4, 5: begin
            cp = arabic_cp();
            put_utf8(cp, utf8_size(cp), utf8_size(cp));
         end
         6: begin
            // overlong Arabic still decodes into range
            cp = arabic_cp();
            put_utf8(cp, 4, 4);
         end
         7, 8: put_byte(neutral_ascii());
         9: begin
            cp = 21'h0;
            put_utf8(cp, $urandom_range(2, 4), 4);
         end
         10:      put_byte(8'($urandom_range(8'h80, 8'hBF)));
         default: put_byte(8'($urandom_range(8'hF8, 8'hFF)));
      endcase
   endfunction

   function automatic void put_bad_unit();
      logic [20:0] cp;
      case ($urandom_range(0, 3))
         0: begin
            case ($urandom_range(0, 2))
               0:       put_byte(8'($urandom_range("a", "z")));
               1:       put_byte(8'($urandom_range("A", "Z")));
               default: put_byte("_");
            endcase
         end
         1: begin
            cp = border_cp();
            put_utf8(cp, utf8_size(cp), utf8_size(cp));
         end
         2: begin
            cp = 21'($urandom_range(21'h80, 21'h1FFFFF));
            put_utf8(cp, utf8_size(cp), utf8_size(cp));
         end
         default: put_utf8(21'($urandom_range(21'h80, 21'h5FF)), 2, 2);
      endcase
   endfunction

   task automatic make_random_string();
      int unsigned kind, units, bad_at, k, nbytes;
      logic [20:0] cp;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
         // raw noise
         repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
      end else begin
         units  = $urandom_range(1, 8);
         bad_at = (kind < 30) ? $urandom_range(0, units - 1) : units;
         for (k = 0; k < units; k++) begin
            if (k == bad_at) put_bad_unit();
            else             put_clean_unit();
         end
         if (kind >= 30 && kind < 45) begin
            // sequence cut short by the end of the string
            cp     = (kind < 38) ? arabic_cp() : 21'($urandom_range(21'h80, 21'h1FFFFF));
            nbytes = $urandom_range(utf8_size(cp) < 2 ? 2 : utf8_size(cp), 4);
            if (nbytes == 4 && $urandom_range(0, 1) == 1) begin
               put_utf8(cp, 4, 1);
               cp = arabic_cp();
               put_utf8(cp, 2, 2);
            end else begin
               put_utf8(cp, nbytes, $urandom_range(1, nbytes - 1));
            end
         end
      end
      end_string();
   endtask

   task automatic make_directed_strings();
      put_byte(8'h00);                                    end_string();
      put_byte("a");                                      end_string();
      put_byte("z");                                      end_string();
      put_byte("_");                                      end_string();
      put_byte(8'h7F);                                    end_string();
      put_byte(8'hD8); put_byte(8'h80);                   end_string();
      put_byte(8'hEF); put_byte(8'hBB); put_byte(8'hBF);  end_string();
      put_byte(8'hC0); put_byte(8'h80);                   end_string();
      put_byte(8'hF0); put_byte(8'h9F);
      put_byte(8'h98); put_byte(8'h80);                   end_string();
      put_byte(8'h80); put_byte(8'hFF);                   end_string();
      // cut-short 4-byte lead; the two bytes after it form an Arabic letter
      put_byte(8'hF0); put_byte(8'hD8); put_byte(8'h80);  end_string();
      put_byte(8'hE0); put_byte("A");                     end_string();
   endtask

   // ---------------- drivers ----------------

   task automatic drive_stream();
      byte_item_type it;
      int            gap;
      bit            no_idle;
      no_idle = 1'b0;
      while (byte_stream.size() > 0) begin
         it = byte_stream.pop_front();
         if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
         gap = no_idle ? 0 : $urandom_range(0, GapMax);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_valid     <= 1'b1;
         req_data_byte <= it.data;
         req_last      <= it.last;
         do @(posedge clock); while (req_stall);
      end
      req_valid <= 1'b0;
   endtask

   initial begin
      make_directed_strings();
      while (byte_stream.size() < RandomItems + 25) make_random_string();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      drive_stream();
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // verdict receiver; one long hold-off lets the DUT back up into its input
   initial begin
      int hold;
      bit no_idle;
      no_idle = 1'b0;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 29) == 0) no_idle = !no_idle;
         if (verdicts_taken == HoldAtVerdict) hold = HoldCycles;
         else hold = no_idle ? 0 : $urandom_range(0, GapMax);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         verdicts_taken++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_run <= 0;
      end else if (idle_run >= WatchdogLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_run <= idle_run + 1;
      end
   end

endmodule
